/* src/dnsa_pkg.sv */
// Package with the shared types and codes of the DNS response A record parser.
`default_nettype none
package dnsa_pkg;

	typedef enum logic [3:0] {
		PH_HEADER  = 4'd0,
		PH_NAME    = 4'd1,
		PH_LABEL   = 4'd2,
		PH_POINTER = 4'd3,
		PH_QFIXED  = 4'd4,
		PH_ASTART  = 4'd5,
		PH_AFIXED  = 4'd6,
		PH_RDSKIP  = 4'd7,
		PH_CAPTURE = 4'd8,
		PH_DONE    = 4'd9
	} phase_t;

	localparam logic [2:0] ST_OK           = 3'd0;
	localparam logic [2:0] ST_TOO_SHORT    = 3'd1;
	localparam logic [2:0] ST_NOT_RESPONSE = 3'd2;
	localparam logic [2:0] ST_RCODE_ERROR  = 3'd3;
	localparam logic [2:0] ST_NO_ANSWERS   = 3'd4;
	localparam logic [2:0] ST_TRUNCATED    = 3'd5;
	localparam logic [2:0] ST_NO_A_RECORD  = 3'd6;

	localparam logic [15:0] FLAG_RESPONSE  = 16'h8000;
	localparam logic [15:0] FLAG_RCODE     = 16'h000F;
	localparam logic [7:0]  POINTER_MASK   = 8'hC0;
	localparam logic [3:0]  HDR_LAST_IDX   = 4'd11;
	localparam logic [3:0]  FIXED_LEN      = 4'd10;
	localparam logic [3:0]  ADDR_LEN       = 4'd4;
	localparam logic [15:0] QFIXED_LEN     = 16'd4;
	localparam logic [15:0] TYPE_A         = 16'd1;
	localparam logic [15:0] A_RDLEN        = 16'd4;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] ip_address;
	} result_t;

endpackage
`default_nettype wire

/* src/dnsa_parser.sv */
// Per-byte parse state and its combinational next-state logic.
`default_nettype none
module dnsa_parser (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            step,
	input  wire logic [7:0]      data_byte,
	input  wire logic            last_byte,
	output dnsa_pkg::result_t    result
);
	import dnsa_pkg::*;

	phase_t      ph_q, ph_d;
	logic [3:0]  hidx_q, hidx_d;
	logic [15:0] flags_q, flags_d;
	logic [15:0] qleft_q, qleft_d;
	logic [15:0] aleft_q, aleft_d;
	logic [15:0] skip_q, skip_d;
	logic [3:0]  cnt_q, cnt_d;
	logic [15:0] rtype_q, rtype_d;
	logic [15:0] rdlen_q, rdlen_d;
	logic [31:0] addr_q, addr_d;
	logic [2:0]  verdict_q, verdict_d;
	logic [15:0] skip_dec, qleft_dec, aleft_dec;
	logic [3:0]  cnt_inc;
	logic [2:0]  fin_status;

	assign skip_dec  = skip_q - 16'd1;
	assign qleft_dec = qleft_q - 16'd1;
	assign aleft_dec = aleft_q - 16'd1;
	assign cnt_inc   = cnt_q + 4'd1;

	always_comb begin
		ph_d      = ph_q;
		hidx_d    = hidx_q;
		flags_d   = flags_q;
		qleft_d   = qleft_q;
		aleft_d   = aleft_q;
		skip_d    = skip_q;
		cnt_d     = cnt_q;
		rtype_d   = rtype_q;
		rdlen_d   = rdlen_q;
		addr_d    = addr_q;
		verdict_d = verdict_q;
		unique case (ph_q)
			PH_HEADER: begin
				hidx_d = hidx_q + 4'd1;
				if (hidx_q == 4'd2 || hidx_q == 4'd3) begin
					flags_d = {flags_q[7:0], data_byte};
				end else if (hidx_q == 4'd4 || hidx_q == 4'd5) begin
					qleft_d = {qleft_q[7:0], data_byte};
				end else if (hidx_q == 4'd6 || hidx_q == 4'd7) begin
					aleft_d = {aleft_q[7:0], data_byte};
				end
				if (hidx_q == HDR_LAST_IDX) begin
					if ((flags_q & FLAG_RESPONSE) == 16'd0) begin
						verdict_d = ST_NOT_RESPONSE;
						ph_d      = PH_DONE;
					end else if ((flags_q & FLAG_RCODE) != 16'd0) begin
						verdict_d = ST_RCODE_ERROR;
						ph_d      = PH_DONE;
					end else if (aleft_q == 16'd0) begin
						verdict_d = ST_NO_ANSWERS;
						ph_d      = PH_DONE;
					end else begin
						ph_d = (qleft_q != 16'd0) ? PH_NAME : PH_ASTART;
					end
				end
			end
			PH_NAME, PH_ASTART: begin
				if ((data_byte & POINTER_MASK) == POINTER_MASK) begin
					ph_d = PH_POINTER;
				end else if (data_byte == 8'd0) begin
					if (qleft_q != 16'd0) begin
						skip_d = QFIXED_LEN;
						ph_d   = PH_QFIXED;
					end else begin
						cnt_d = 4'd0;
						ph_d  = PH_AFIXED;
					end
				end else begin
					skip_d = {8'd0, data_byte};
					ph_d   = PH_LABEL;
				end
			end
			PH_LABEL: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					ph_d = PH_NAME;
				end
			end
			PH_POINTER: begin
				if (qleft_q != 16'd0) begin
					skip_d = QFIXED_LEN;
					ph_d   = PH_QFIXED;
				end else begin
					cnt_d = 4'd0;
					ph_d  = PH_AFIXED;
				end
			end
			PH_QFIXED: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					qleft_d = qleft_dec;
					ph_d    = (qleft_dec != 16'd0) ? PH_NAME : PH_ASTART;
				end
			end
			PH_AFIXED: begin
				if (cnt_q < 4'd2) begin
					rtype_d = {rtype_q[7:0], data_byte};
				end else if (cnt_q >= 4'd8) begin
					rdlen_d = {rdlen_q[7:0], data_byte};
				end
				cnt_d = cnt_inc;
				if (cnt_inc >= FIXED_LEN) begin
					cnt_d = 4'd0;
					if (rtype_d == TYPE_A && rdlen_d == A_RDLEN) begin
						addr_d = 32'd0;
						ph_d   = PH_CAPTURE;
					end else if (rdlen_d == 16'd0) begin
						aleft_d = aleft_dec;
						if (aleft_dec == 16'd0) begin
							verdict_d = ST_NO_A_RECORD;
							ph_d      = PH_DONE;
						end else begin
							ph_d = PH_ASTART;
						end
					end else begin
						skip_d = rdlen_d;
						ph_d   = PH_RDSKIP;
					end
				end
			end
			PH_RDSKIP: begin
				skip_d = skip_dec;
				if (skip_dec == 16'd0) begin
					aleft_d = aleft_dec;
					if (aleft_dec == 16'd0) begin
						verdict_d = ST_NO_A_RECORD;
						ph_d      = PH_DONE;
					end else begin
						ph_d = PH_ASTART;
					end
				end
			end
			PH_CAPTURE: begin
				addr_d = {addr_q[23:0], data_byte};
				cnt_d  = cnt_inc;
				if (cnt_inc >= ADDR_LEN) begin
					verdict_d = ST_OK;
					ph_d      = PH_DONE;
				end
			end
			PH_DONE: begin
				// Verdict is decided; remaining bytes of the packet are ignored.
			end
			default: begin
				ph_d = ph_q;
			end
		endcase
	end

	// Status as seen right after this byte has been consumed.
	always_comb begin
		priority if (ph_d == PH_DONE) begin
			fin_status = verdict_d;
		end else if (ph_d == PH_HEADER) begin
			fin_status = ST_TOO_SHORT;
		end else if (ph_d == PH_AFIXED || ph_d == PH_CAPTURE) begin
			fin_status = ST_TRUNCATED;
		end else if ((ph_d == PH_NAME || ph_d == PH_LABEL || ph_d == PH_POINTER)
				&& qleft_d == 16'd0) begin
			fin_status = ST_TRUNCATED;
		end else begin
			fin_status = ST_NO_A_RECORD;
		end
	end

	assign result.status     = fin_status;
	assign result.ip_address = (fin_status == ST_OK) ? addr_d : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q      <= PH_HEADER;
			hidx_q    <= 4'd0;
			flags_q   <= 16'd0;
			qleft_q   <= 16'd0;
			aleft_q   <= 16'd0;
			skip_q    <= 16'd0;
			cnt_q     <= 4'd0;
			rtype_q   <= 16'd0;
			rdlen_q   <= 16'd0;
			addr_q    <= 32'd0;
			verdict_q <= ST_OK;
		end else if (step) begin
			if (last_byte) begin
				ph_q      <= PH_HEADER;
				hidx_q    <= 4'd0;
				flags_q   <= 16'd0;
				qleft_q   <= 16'd0;
				aleft_q   <= 16'd0;
				skip_q    <= 16'd0;
				cnt_q     <= 4'd0;
				rtype_q   <= 16'd0;
				rdlen_q   <= 16'd0;
				addr_q    <= 32'd0;
				verdict_q <= ST_OK;
			end else begin
				ph_q      <= ph_d;
				hidx_q    <= hidx_d;
				flags_q   <= flags_d;
				qleft_q   <= qleft_d;
				aleft_q   <= aleft_d;
				skip_q    <= skip_d;
				cnt_q     <= cnt_d;
				rtype_q   <= rtype_d;
				rdlen_q   <= rdlen_d;
				addr_q    <= addr_d;
				verdict_q <= verdict_d;
			end
		end
	end

endmodule
`default_nettype wire

/* src/dns_response_a_record_parser.sv */
// Top level of the DNS response A record parser: input and result registers.
//
// The block takes a DNS response packet one byte per request on the input
// channel (in_valid/in_ready, data_byte, last_byte), last_byte marking the
// final byte. It checks the 12-byte header, skips the question section and
// walks the answer records, looking for the first type A record whose rdata
// length is 4. Exactly one result request (out_valid/out_ready, status,
// ip_address) is produced per packet, for its last byte; ip_address holds
// the address only when status is ok and is zero otherwise.
//
// Each byte is first captured in an input register, then the parse state is
// updated from it and, for a last byte, the result register is loaded. A
// result is thus offered once its last byte has left the input register.
// The block takes one byte in every cycle unless a last byte is held back;
// the parse state takes each byte as it leaves the input register. When
// the receiver stalls, bytes that are not the last of a packet keep flowing;
// a last byte waits in the input register until the result register is free,
// and in_ready drops only then.
// Reset clears both registers' valid flags and returns the parser to the
// start of a packet; after each packet's last byte it returns there as well.
`default_nettype none
module dns_response_a_record_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       status,
	output logic [31:0]      ip_address
);
	import dnsa_pkg::*;

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;
	logic        out_vld_q;
	logic [2:0]  status_q;
	logic [31:0] ip_q;
	result_t     result;

	// A byte moves into the parser unless it is a last byte facing a full,
	// stalled result register.
	assign advance  = vld_s1 && (!last_s1 || !out_vld_q || out_ready);
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			vld_s1 <= 1'b1;
		end else if (advance) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	dnsa_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= result.status;
			ip_q     <= result.ip_address;
		end
	end

	assign out_valid  = out_vld_q;
	assign status     = status_q;
	assign ip_address = ip_q;

endmodule
`default_nettype wire
